[rtl/region_registry_table_top_defines.svh]
// Assertion macros shared by the region registry table RTL.
`ifndef REGION_REGISTRY_TABLE_TOP_DEFINES_SVH
`define REGION_REGISTRY_TABLE_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define RRT_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define RRT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/rrt_pkg.sv]
// ----------------------------------------------------------------------------
// rrt_pkg
// Types and codes shared by the region registry table cells and top level.
// ----------------------------------------------------------------------------
package rrt_pkg;

   localparam logic ACT_REGISTER = 1'b0;
   localparam logic ACT_LOOKUP   = 1'b1;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_OVERLAP   = 2'd1;
   localparam logic [1:0] ST_NOT_FOUND = 2'd2;
   localparam logic [1:0] ST_FULL      = 2'd3;

   typedef struct packed {
      logic [63:0] range_start;
      logic [63:0] range_end;
      logic [2:0]  domain;
      logic [31:0] attributes;
   } rrt_slot_type;

   typedef struct packed {
      logic         valid;
      logic         action;
      logic [63:0]  range_start;
      logic [63:0]  range_end;
      logic         hit;
      logic [3:0]   hit_slot;
      rrt_slot_type hit_region;
   } rrt_token_type;

   typedef struct packed {
      logic [1:0]   status;
      logic [3:0]   hit_slot;
      rrt_slot_type hit_region;
   } rrt_result_type;

   typedef enum logic [1:0] {
      SM_IDLE,
      SM_SCAN,
      SM_HOLD
   } rrt_state_type;

endpackage

[rtl/rrt_cell.sv]
// ----------------------------------------------------------------------------
// rrt_cell
// One table slot. Compares the passing request against its region and hands
// the request on to the next slot in the following cycle, overriding the carried hit on a match.
// ----------------------------------------------------------------------------
module rrt_cell import rrt_pkg::*; #(
   parameter int SLOT_INDEX = 0
) (
   input  logic          clock,
   input  logic          reset,
   input  rrt_token_type up_tok,
   input  logic          wr_en,
   input  rrt_slot_type  wr_data,
   output rrt_token_type down_tok
);

   logic          valid_ff;
   logic          valid_in;
   rrt_slot_type  slot_ff;
   rrt_token_type tok_ff;
   rrt_token_type tok_in;
   logic          match;

   always_comb begin
      if (up_tok.action == ACT_REGISTER) begin
         // half-open overlap test
         match = !((up_tok.range_end <= slot_ff.range_start) ||
                   (up_tok.range_start >= slot_ff.range_end));
      end else begin
         match = (up_tok.range_start >= slot_ff.range_start) &&
                 (up_tok.range_end <= slot_ff.range_end);
      end
   end

   always_comb begin
      tok_in = up_tok;
      // later slots are newer, so a hit here replaces any earlier one
      if (up_tok.valid && valid_ff && match) begin
         tok_in.hit        = 1'b1;
         tok_in.hit_slot   = 4'(SLOT_INDEX);
         tok_in.hit_region = slot_ff;
      end
   end

   assign valid_in = valid_ff | wr_en;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= 1'b0;
         tok_ff.valid <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         tok_ff   <= tok_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_ff <= wr_data;
      end
   end

   assign down_tok = tok_ff;

endmodule

[rtl/region_registry_table_top.sv]
// ----------------------------------------------------------------------------
// region_registry_table_top
// Table of address regions with overlap check on register and newest covering
// region search on lookup, built as a chain of slot cells.
// ----------------------------------------------------------------------------
//   channel   ports              direction   payload
//   request   req_valid/ready    in          action, range, domain, attributes
//   response  rsp_valid/ready    out         status, hit region fields, slot
//
// A request walks the slot chain one cell per cycle. Its result is captured
// as it leaves the last cell and moved to the output register once that is
// free or being read; only then is the next request taken, one request in
// the chain at a time. A finished response waits in its output register
// while the next request walks the chain. Reset empties the table at once.
// Response stalls hold the block only once a second finished result is held.
`include "region_registry_table_top_defines.svh"

module region_registry_table_top import rrt_pkg::*; #(
   parameter int TABLE_ENTRIES = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_action,
   input  logic [63:0] req_range_start,
   input  logic [63:0] req_range_end,
   input  logic [2:0]  req_region_domain,
   input  logic [31:0] req_region_attributes,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic [63:0] rsp_hit_start,
   output logic [63:0] rsp_hit_end,
   output logic [2:0]  rsp_hit_domain,
   output logic [31:0] rsp_hit_attributes,
   output logic [3:0]  rsp_hit_slot
);

   localparam int CW = $clog2(TABLE_ENTRIES + 1);

   rrt_state_type  state_ff;
   rrt_state_type  state_in;
   logic [CW-1:0]  count_ff;
   logic [CW-1:0]  count_in;
   logic [2:0]     domain_ff;
   logic [31:0]    attributes_ff;
   rrt_result_type res_ff;
   rrt_result_type res_in;
   rrt_result_type rsp_ff;
   logic           rsp_valid_ff;
   logic           rsp_valid_in;

   rrt_token_type  chain [TABLE_ENTRIES + 1];
   rrt_token_type  head_tok;
   rrt_token_type  last_tok;
   rrt_slot_type   wr_data;
   logic           accept;
   logic           capture;
   logic           release_rsp;
   logic           full;
   logic           wr_en;

   assign accept   = req_valid & req_ready;
   assign last_tok = chain[TABLE_ENTRIES];
   assign full     = (count_ff == CW'(TABLE_ENTRIES));

   // inject the request at the head of the chain
   always_comb begin
      head_tok             = '0;
      head_tok.valid       = accept;
      head_tok.action      = req_action;
      head_tok.range_start = req_range_start;
      head_tok.range_end   = req_range_end;
   end

   assign chain[0] = head_tok;

   always_comb begin
      wr_data.range_start = last_tok.range_start;
      wr_data.range_end   = last_tok.range_end;
      wr_data.domain      = domain_ff;
      wr_data.attributes  = attributes_ff;
   end

   for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
      rrt_cell #(
         .SLOT_INDEX(g)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .up_tok   (chain[g]),
         .wr_en    (wr_en && (count_ff == CW'(g))),
         .wr_data  (wr_data),
         .down_tok (chain[g + 1])
      );
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         SM_IDLE: if (accept) state_in = SM_SCAN;
         SM_SCAN: if (last_tok.valid) state_in = SM_HOLD;
         SM_HOLD: if (!rsp_valid_ff || rsp_ready) state_in = SM_IDLE;
         default: state_in = SM_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      req_ready   = 1'b0;
      capture     = 1'b0;
      release_rsp = 1'b0;
      unique case (state_ff)
         SM_IDLE: req_ready = 1'b1;
         SM_SCAN: capture = last_tok.valid;
         SM_HOLD: release_rsp = !rsp_valid_ff || rsp_ready;
         default: ;
      endcase
   end

   assign wr_en = capture && (last_tok.action == ACT_REGISTER) && !last_tok.hit && !full;

   always_comb begin
      res_in = '0;
      if (last_tok.action == ACT_LOOKUP) begin
         if (last_tok.hit) begin
            res_in.status     = ST_OK;
            res_in.hit_slot   = last_tok.hit_slot;
            res_in.hit_region = last_tok.hit_region;
         end else begin
            res_in.status = ST_NOT_FOUND;
         end
      end else if (last_tok.hit) begin
         res_in.status   = ST_OVERLAP;
         res_in.hit_slot = last_tok.hit_slot;
      end else if (full) begin
         res_in.status = ST_FULL;
      end else begin
         res_in.status   = ST_OK;
         res_in.hit_slot = 4'(count_ff);
      end
   end

   assign count_in = wr_en ? count_ff + CW'(1) : count_ff;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (release_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= SM_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         domain_ff     <= req_region_domain;
         attributes_ff <= req_region_attributes;
      end
      if (capture) begin
         res_ff <= res_in;
      end
      if (release_rsp) begin
         rsp_ff <= res_ff;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_ff.status;
   assign rsp_hit_start      = rsp_ff.hit_region.range_start;
   assign rsp_hit_end        = rsp_ff.hit_region.range_end;
   assign rsp_hit_domain     = rsp_ff.hit_region.domain;
   assign rsp_hit_attributes = rsp_ff.hit_region.attributes;
   assign rsp_hit_slot       = rsp_ff.hit_slot;

   `RRT_ASSERT_SAME(a_write_not_full, clock, reset, wr_en, !full,
      "slot write with table full")
   `RRT_ASSERT_NEXT(a_accept_scans, clock, reset, accept, state_ff == SM_SCAN,
      "accepted request did not start a scan")
   `RRT_ASSERT_SAME(a_tail_in_scan, clock, reset, last_tok.valid, state_ff == SM_SCAN,
      "request left the chain outside a scan")
   `RRT_ASSERT_NEXT(a_release_valid, clock, reset, release_rsp, rsp_valid_ff,
      "released result not shown on the response port")

endmodule
